// File: hdl/ecrr_pkg.sv
`default_nettype none

package ecrr_pkg;

  // Width of the shared divider; covers the magnitude of any counter value.
  localparam int unsigned DIV_W     = 32;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

  // (c / 3) / 3 under truncation equals c / 9; for any 32-bit magnitude x,
  // x / 9 = (x * NINE_RECIP) >> NINE_SHIFT.
  localparam logic [31:0] NINE_RECIP = 32'h38E3_8E39;
  localparam int unsigned NINE_SHIFT = 33;

  localparam logic [31:0] SEED_RESET = 32'd1;

  // Request into the shared divider.
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  // Status and results from the shared divider.
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: hdl/ecrr_div.sv
`default_nettype none

// Unsigned restoring divider, one quotient bit per cycle.
module ecrr_div
  import ecrr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [DIV_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W-1:0]     dvs_r, dvs_nxt;
  logic [DIV_W:0]       trial;
  logic [DIV_W:0]       shifted;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    shifted  = {rem_r, quo_r[DIV_W-1]};
    trial    = shifted - {1'b0, dvs_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_W - 1);
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      // Subtract when the divisor fits, else shift the partial remainder.
      if (!trial[DIV_W]) begin
        rem_nxt = trial[DIV_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DIV_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy      = busy_r;
  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while busy");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while still busy");

  a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && $past(cnt_r) == '0)
    else $error("divider done without finishing the last step");

endmodule

`default_nettype wire

// File: hdl/evolved_counter_rng_ranged.sv
`default_nettype none

// Ranged pseudo-random generator. Each input word carries a signed range
// (range_low, range_high); the block answers with one word holding a value in
// [range_low, range_high], or zero with range_error set when high is below low.
// The value comes from B generator bits, B being the bit length of n - 1, where
// n is range_high + 1 for a non-negative low and range_high + 1 - range_low
// otherwise. Each bit is derived from a signed 32-bit position counter c as
// v = c / (c % (2 - c/9)) with the zero cases forced to 1; the bit is set when
// v is odd and positive. The counter advances by one per bit and wraps. Bits
// are packed LSB first, reduced mod (high + 1 - low) and offset by low.
// Writing cfg_data loads the counter; reset loads 1. Configuration is only
// meant to be written while no request is in flight.
// Sequencing: divisions run through one shared 32-bit restoring divider that
// yields one quotient bit per cycle; c/9 comes from a combinational reciprocal
// multiply registered in ST_BIT. Each bit passes ST_BIT and ST_Q, then up to
// two divisions (c % d in ST_REM, then c / m in ST_QUO); a zero d skips the
// first division and a zero remainder skips the second. The range reduction
// is set up in ST_BIT and runs one division in ST_MOD, and the result word
// passes ST_OUT, which holds while the output register is still full. A range
// error goes from ST_IDLE straight to ST_OUT.
// The input side is ready only while the sequencer is idle; a finished result
// sits in the output register and the next request is taken meanwhile.
module evolved_counter_rng_ranged
  import ecrr_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  // in_tdata: range_low [VALUE_BITS-1:0], range_high [2*VALUE_BITS-1:VALUE_BITS]
  input  wire logic [((2*VALUE_BITS+7)/8)*8-1:0]      in_tdata,
  input  wire logic                                   in_tvalid,
  output logic                                        in_tready,
  // out_tdata: random_value [VALUE_BITS-1:0]
  output logic [((VALUE_BITS+7)/8)*8-1:0]             out_tdata,
  // out_tuser: range_error [0]
  output logic                                        out_tuser,
  output logic                                        out_tvalid,
  input  wire logic                                   out_tready,
  input  wire logic [31:0]                            cfg_data,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready
);

  localparam int unsigned VB    = VALUE_BITS;
  localparam int unsigned NW    = VALUE_BITS + 1;
  localparam int unsigned OUT_W = ((VALUE_BITS + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIT,
    ST_Q,
    ST_REM,
    ST_QUO,
    ST_MOD,
    ST_OUT
  } state_t;

  state_t          state_r, state_nxt;
  logic [31:0]     ctr_r, ctr_nxt;
  logic [VB-1:0]   lo_r, lo_nxt;
  logic [NW-1:0]   span_r, span_nxt;
  logic [NW-1:0]   left_r, left_nxt;     // n - 1, shifted right once per bit
  logic [NW-1:0]   dec_r, dec_nxt;
  logic [NW-1:0]   wgt_r, wgt_nxt;       // one-hot weight of the next bit
  logic            mneg_r, mneg_nxt;
  logic            go_r, go_nxt;
  logic [DIV_W-1:0] opa_r, opa_nxt;
  logic [DIV_W-1:0] opb_r, opb_nxt;
  logic [DIV_W-1:0] q9_r, q9_nxt;        // |c| / 9
  logic [VB-1:0]   res_val_r, res_val_nxt;
  logic            res_err_r, res_err_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [VB-1:0]   out_val_r, out_val_nxt;
  logic            out_err_r, out_err_nxt;

  div_req_t        dreq;
  div_rsp_t        drsp;

  logic signed [VB-1:0] lo_in, hi_in;
  logic [NW-1:0]   lo_ext, hi_ext, diff;
  logic            c_neg;
  logic [31:0]     c_mag;
  logic [63:0]     q9_prod;
  logic [33:0]     q_s, d_s, d_mag;
  logic            bit_val, bit_done;

  ecrr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  assign dreq.start    = go_r;
  assign dreq.dividend = opa_r;
  assign dreq.divisor  = opb_r;

  always_comb begin
    lo_in   = $signed(in_tdata[VB-1:0]);
    hi_in   = $signed(in_tdata[2*VB-1:VB]);
    lo_ext  = {lo_in[VB-1], lo_in};
    hi_ext  = {hi_in[VB-1], hi_in};
    diff    = hi_ext - lo_ext;
    c_neg   = ctr_r[31];
    c_mag   = c_neg ? (~ctr_r + 32'd1) : ctr_r;
    q9_prod = {32'd0, c_mag} * {32'd0, NINE_RECIP};
    // Signed c/9 rebuilt from its magnitude, then d = 2 - q and |d|.
    q_s     = c_neg ? (~{2'b00, q9_r} + 34'd1) : {2'b00, q9_r};
    d_s     = 34'd2 - q_s;
    d_mag   = d_s[33] ? (~d_s + 34'd1) : d_s;

    state_nxt     = state_r;
    ctr_nxt       = ctr_r;
    lo_nxt        = lo_r;
    span_nxt      = span_r;
    left_nxt      = left_r;
    dec_nxt       = dec_r;
    wgt_nxt       = wgt_r;
    mneg_nxt      = mneg_r;
    go_nxt        = 1'b0;
    opa_nxt       = opa_r;
    opb_nxt       = opb_r;
    q9_nxt        = q9_r;
    res_val_nxt   = res_val_r;
    res_err_nxt   = res_err_r;
    out_valid_nxt = out_valid_r;
    out_val_nxt   = out_val_r;
    out_err_nxt   = out_err_r;
    bit_val       = 1'b0;
    bit_done      = 1'b0;

    // Drop the result once the sink takes it.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          lo_nxt = lo_in;
          if (hi_in < lo_in) begin
            res_val_nxt = '0;
            res_err_nxt = 1'b1;
            state_nxt   = ST_OUT;
          end else begin
            left_nxt    = lo_in[VB-1] ? diff : hi_ext;
            span_nxt    = diff + NW'(1);
            dec_nxt     = '0;
            wgt_nxt     = NW'(1);
            res_err_nxt = 1'b0;
            state_nxt   = ST_BIT;
          end
        end
      end
      ST_BIT: begin
        if (left_r == '0) begin
          // All bits gathered: reduce mod span.
          go_nxt    = 1'b1;
          opa_nxt   = DIV_W'(dec_r);
          opb_nxt   = DIV_W'(span_r);
          state_nxt = ST_MOD;
        end else begin
          // Take |c| / 9 from the reciprocal product.
          q9_nxt    = DIV_W'(q9_prod[63:NINE_SHIFT]);
          state_nxt = ST_Q;
        end
      end
      ST_Q: begin
        go_nxt  = 1'b1;
        opa_nxt = c_mag;
        if (d_s == '0) begin
          // Zero divisor: m is forced to 1.
          opb_nxt   = DIV_W'(1);
          mneg_nxt  = 1'b0;
          state_nxt = ST_QUO;
        end else begin
          opb_nxt   = d_mag[31:0];
          state_nxt = ST_REM;
        end
      end
      ST_REM: begin
        if (drsp.done) begin
          if (drsp.remainder == '0) begin
            // Zero remainder: v is forced to 1, so the bit is set.
            bit_val  = 1'b1;
            bit_done = 1'b1;
          end else begin
            go_nxt    = 1'b1;
            opa_nxt   = c_mag;
            opb_nxt   = drsp.remainder;
            mneg_nxt  = c_neg;
            state_nxt = ST_QUO;
          end
        end
      end
      ST_QUO: begin
        if (drsp.done) begin
          // Odd and non-negative; a zero quotient is even, so no sign issue.
          bit_val  = drsp.quotient[0] & ~(c_neg ^ mneg_r);
          bit_done = 1'b1;
        end
      end
      ST_MOD: begin
        if (drsp.done) begin
          res_val_nxt = drsp.remainder[VB-1:0] + lo_r;
          state_nxt   = ST_OUT;
        end
      end
      ST_OUT: begin
        // Hold until the output register is free.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_val_r;
          out_err_nxt   = res_err_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (bit_done) begin
      if (bit_val) begin
        dec_nxt = dec_r | wgt_r;
      end
      wgt_nxt   = wgt_r << 1;
      left_nxt  = left_r >> 1;
      ctr_nxt   = ctr_r + 32'd1;
      state_nxt = ST_BIT;
    end

    // Load the counter from cfg_data.
    if (cfg_valid) begin
      ctr_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ctr_r       <= SEED_RESET;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ctr_r       <= ctr_nxt;
      go_r        <= go_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lo_r      <= lo_nxt;
    span_r    <= span_nxt;
    left_r    <= left_nxt;
    dec_r     <= dec_nxt;
    wgt_r     <= wgt_nxt;
    mneg_r    <= mneg_nxt;
    opa_r     <= opa_nxt;
    opb_r     <= opb_nxt;
    q9_r      <= q9_nxt;
    res_val_r <= res_val_nxt;
    res_err_r <= res_err_nxt;
    out_val_r <= out_val_nxt;
    out_err_r <= out_err_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_val_r);
  assign out_tuser  = out_err_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("range error reported with nonzero value");

  a_ctr_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(cfg_valid) &&
    ($past(state_r) == ST_IDLE || $past(state_r) == ST_OUT ||
     $past(state_r) == ST_MOD) |-> $stable(ctr_r))
    else $error("counter moved outside bit generation");

  a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !drsp.busy && !go_r)
    else $error("divider active while idle");

  a_mod_last: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MOD |-> left_r == '0)
    else $error("range reduction started with bits outstanding");

endmodule

`default_nettype wire
